// File: rtl/core/rk4os_pkg.sv
// ----------------------------------------------------------------------------
// rk4os_pkg: shared types and constants
// Fixed-point formats, channel words, register indexes and the control
// program of the oscillator step core.
// ----------------------------------------------------------------------------
package rk4os_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 24;
  localparam int STEP_SIZE_W = 31;
  localparam int IDX_W       = 3;
  localparam int SUM_W       = DATA_W + 3;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int STEP_W      = 5;

  typedef logic signed [DATA_W-1:0] fix_t;

  localparam logic [IDX_W-1:0] REG_STEP_SIZE        = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FINAL_TIME       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INITIAL_TIME     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_INITIAL_POSITION = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_INITIAL_VELOCITY = IDX_W'(4);

  localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RST = STEP_SIZE_W'(1677722);
  localparam fix_t FINAL_TIME_RST       = DATA_W'(167772160);
  localparam fix_t INITIAL_TIME_RST     = DATA_W'(0);
  localparam fix_t INITIAL_POSITION_RST = DATA_W'(16777216);
  localparam fix_t INITIAL_VELOCITY_RST = DATA_W'(0);

  // Reciprocal of three scaled by 2^DATA_W, rounded up.
  localparam fix_t RECIP_THIRD = 32'h5555_5556;

  typedef struct packed {
    logic restart;
  } cmd_word_t;

  typedef struct packed {
    fix_t time_now;
    fix_t position;
    fix_t velocity;
    logic finished;
    logic overflow;
  } rsp_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } cfg_word_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_H6,
    OP_TP,
    OP_TV,
    OP_SLOPE,
    OP_SUMSAT,
    OP_NEWP,
    OP_NEWV,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    MA_HH,
    MA_H,
    MA_H6
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_RECIP,
    MB_KP,
    MB_KV,
    MB_SP,
    MB_SV
  } mul_b_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_SKIP,
    JC_HOLD
  } jcond_t;

  typedef struct packed {
    op_t               op;
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    logic              weight2;
    jcond_t            jcond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_word_t;

  typedef struct packed {
    logic       en;
    ctrl_word_t cw;
  } dp_ctrl_t;

  typedef struct packed {
    logic skip;
    logic hold;
  } seq_status_t;

  localparam logic [STEP_W-1:0] STEP_OUT = STEP_W'(18);

  function automatic ctrl_word_t mk_cw(input op_t op, input mul_a_t ma, input mul_b_t mb,
                                       input logic w2, input jcond_t jc, input logic last);
    ctrl_word_t c;
    c.op      = op;
    c.mul_a   = ma;
    c.mul_b   = mb;
    c.weight2 = w2;
    c.jcond   = jc;
    c.target  = STEP_OUT;
    c.last    = last;
    return c;
  endfunction

  // The product register always holds the result of the previous step's
  // operand selection, so each add step consumes what the step before issued.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t c;
    case (int'(step))
      0:       c = mk_cw(OP_START,  MA_HH, MB_KP,    1'b0, JC_SKIP, 1'b0);
      1:       c = mk_cw(OP_NOP,    MA_HH, MB_RECIP, 1'b0, JC_NONE, 1'b0);
      2:       c = mk_cw(OP_H6,     MA_HH, MB_KP,    1'b0, JC_NONE, 1'b0);
      3:       c = mk_cw(OP_TP,     MA_HH, MB_KV,    1'b0, JC_NONE, 1'b0);
      4:       c = mk_cw(OP_TV,     MA_HH, MB_KP,    1'b0, JC_NONE, 1'b0);
      5:       c = mk_cw(OP_SLOPE,  MA_HH, MB_KP,    1'b1, JC_NONE, 1'b0);
      6:       c = mk_cw(OP_NOP,    MA_HH, MB_KP,    1'b0, JC_NONE, 1'b0);
      7:       c = mk_cw(OP_TP,     MA_HH, MB_KV,    1'b0, JC_NONE, 1'b0);
      8:       c = mk_cw(OP_TV,     MA_H,  MB_KP,    1'b0, JC_NONE, 1'b0);
      9:       c = mk_cw(OP_SLOPE,  MA_H,  MB_KP,    1'b1, JC_NONE, 1'b0);
      10:      c = mk_cw(OP_NOP,    MA_H,  MB_KP,    1'b0, JC_NONE, 1'b0);
      11:      c = mk_cw(OP_TP,     MA_H,  MB_KV,    1'b0, JC_NONE, 1'b0);
      12:      c = mk_cw(OP_TV,     MA_H,  MB_KP,    1'b0, JC_NONE, 1'b0);
      13:      c = mk_cw(OP_SLOPE,  MA_H,  MB_KP,    1'b0, JC_NONE, 1'b0);
      14:      c = mk_cw(OP_SUMSAT, MA_H6, MB_SP,    1'b0, JC_NONE, 1'b0);
      15:      c = mk_cw(OP_NOP,    MA_H6, MB_SP,    1'b0, JC_NONE, 1'b0);
      16:      c = mk_cw(OP_NEWP,   MA_H6, MB_SV,    1'b0, JC_NONE, 1'b0);
      17:      c = mk_cw(OP_NEWV,   MA_H6, MB_SV,    1'b0, JC_NONE, 1'b0);
      18:      c = mk_cw(OP_OUT,    MA_H6, MB_SV,    1'b0, JC_HOLD, 1'b1);
      default: c = mk_cw(OP_NOP,    MA_HH, MB_KP,    1'b0, JC_NONE, 1'b1);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/rk4os_ifs.sv
// ----------------------------------------------------------------------------
// rk4os channel interfaces
// Valid/ready channels for the command, response and configuration words.
// ----------------------------------------------------------------------------
interface rk4os_cmd_if;
  import rk4os_pkg::*;
  logic      valid;
  logic      ready;
  cmd_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface rk4os_rsp_if;
  import rk4os_pkg::*;
  logic      valid;
  logic      ready;
  rsp_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface rk4os_cfg_if;
  import rk4os_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// File: rtl/core/rk4_oscillator_step_core.sv
// ----------------------------------------------------------------------------
// rk4_oscillator_step_core: RK4 step of the harmonic oscillator
// Microcoded fixed-point integrator with one shared multiplier.
//
//   Port  Role    Word fields
//   cmd   sink    restart
//   rsp   source  time_now, position, velocity, finished, overflow
//   cfg   sink    index, value (step_size, final_time, initial_time,
//                 initial_position, initial_velocity)
//
// An advancing step runs 19 control steps on the shared 32x32 multiplier, one
// per cycle but for the last step's hold; a restart or an already finished
// step runs 2. A new command word is taken once the previous program has
// handed its response to the output register, even while that response waits.
// The last control step holds while a full response register is not taken.
// Reset is synchronous and loads the register defaults; state reads zero.
// ----------------------------------------------------------------------------
module rk4_oscillator_step_core (
  input  logic        clk,
  input  logic        rst,
  rk4os_cmd_if.sink   cmd,
  rk4os_rsp_if.source rsp,
  rk4os_cfg_if.sink   cfg
);
  import rk4os_pkg::*;

  logic [STEP_SIZE_W-1:0] step_size;
  fix_t                   final_time;
  fix_t                   initial_time;
  fix_t                   initial_position;
  fix_t                   initial_velocity;

  dp_ctrl_t    ctrl;
  seq_status_t status;
  logic        cmd_accept;
  logic        out_load;
  fix_t        dp_time;
  fix_t        dp_pos;
  fix_t        dp_vel;
  logic        dp_finished;
  logic        dp_overflow;
  logic        rsp_valid;
  rsp_word_t   rsp_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= STEP_SIZE_RST;
      final_time       <= FINAL_TIME_RST;
      initial_time     <= INITIAL_TIME_RST;
      initial_position <= INITIAL_POSITION_RST;
      initial_velocity <= INITIAL_VELOCITY_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.word.index)
        REG_STEP_SIZE:        step_size        <= cfg.word.value[STEP_SIZE_W-1:0];
        REG_FINAL_TIME:       final_time       <= cfg.word.value;
        REG_INITIAL_TIME:     initial_time     <= cfg.word.value;
        REG_INITIAL_POSITION: initial_position <= cfg.word.value;
        REG_INITIAL_VELOCITY: initial_velocity <= cfg.word.value;
        default: begin
        end
      endcase
    end
  end

  assign cmd.ready   = !ctrl.en;
  assign cmd_accept  = cmd.valid && cmd.ready;
  assign status.hold = rsp_valid && !rsp.ready;

  rk4os_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd_accept),
    .status (status),
    .ctrl   (ctrl)
  );

  rk4os_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .load             (cmd_accept),
    .restart          (cmd.word.restart),
    .step_size        (step_size),
    .final_time       (final_time),
    .initial_time     (initial_time),
    .initial_position (initial_position),
    .initial_velocity (initial_velocity),
    .ctrl             (ctrl),
    .time_now         (dp_time),
    .position         (dp_pos),
    .velocity         (dp_vel),
    .finished         (dp_finished),
    .overflow         (dp_overflow),
    .skip             (status.skip)
  );

  assign out_load = ctrl.en && ctrl.cw.op == OP_OUT && !status.hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (out_load) begin
      rsp_word.time_now <= dp_time;
      rsp_word.position <= dp_pos;
      rsp_word.velocity <= dp_vel;
      rsp_word.finished <= dp_finished;
      rsp_word.overflow <= dp_overflow;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.word  = rsp_word;

`ifndef SYNTHESIS
  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> ctrl.en && ctrl.cw.op == OP_START)
    else $error("accepted command did not start the program");

  a_no_step_past_final: assert property (@(posedge clk) disable iff (rst)
    ctrl.en && ctrl.cw.op == OP_NEWV |-> !dp_finished)
    else $error("state advanced after final time was reached");

  a_rsp_from_out_step: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctrl.en && ctrl.cw.op == OP_OUT))
    else $error("response loaded outside the output step");
`endif

endmodule

// File: rtl/core/rk4os_sequencer.sv
// ----------------------------------------------------------------------------
// rk4os_sequencer: microprogram sequencer
// Step counter over the control program with skip and hold jumps.
// ----------------------------------------------------------------------------
module rk4os_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rk4os_pkg::seq_status_t status,
  output rk4os_pkg::dp_ctrl_t    ctrl
);
  import rk4os_pkg::*;

  logic              busy;
  logic              busy_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_word_t        cw;

  assign cw = ucode(step);

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (busy) begin
      if (cw.jcond == JC_SKIP && status.skip) begin
        step_next = cw.target;
      end else if (cw.jcond == JC_HOLD && status.hold) begin
        step_next = step;
      end else if (cw.last) begin
        busy_next = 1'b0;
      end else begin
        step_next = step + 1'b1;
      end
    end else if (start) begin
      busy_next = 1'b1;
      step_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  assign ctrl.en = busy;
  assign ctrl.cw = cw;

endmodule

// File: rtl/core/rk4os_datapath.sv
// ----------------------------------------------------------------------------
// rk4os_datapath: state registers, shared multiplier and saturating adders
// Executes one control word per cycle on the oscillator state.
// ----------------------------------------------------------------------------
module rk4os_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic                                   restart,
  input  logic [rk4os_pkg::STEP_SIZE_W-1:0]      step_size,
  input  rk4os_pkg::fix_t                        final_time,
  input  rk4os_pkg::fix_t                        initial_time,
  input  rk4os_pkg::fix_t                        initial_position,
  input  rk4os_pkg::fix_t                        initial_velocity,
  input  rk4os_pkg::dp_ctrl_t                    ctrl,
  output rk4os_pkg::fix_t                        time_now,
  output rk4os_pkg::fix_t                        position,
  output rk4os_pkg::fix_t                        velocity,
  output logic                                   finished,
  output logic                                   overflow,
  output logic                                   skip
);
  import rk4os_pkg::*;

  typedef struct packed {
    fix_t v;
    logic of;
  } sat_t;

  localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_W - 1);

  function automatic sat_t sat_add(input fix_t a, input fix_t b);
    logic signed [DATA_W:0] s;
    sat_t r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    r.of = s[DATA_W] != s[DATA_W-1];
    r.v  = r.of ? (s[DATA_W] ? FIX_MIN : FIX_MAX) : s[DATA_W-1:0];
    return r;
  endfunction

  function automatic sat_t sat_neg(input fix_t a);
    sat_t r;
    r.of = a == FIX_MIN;
    r.v  = r.of ? FIX_MAX : -a;
    return r;
  endfunction

  function automatic sat_t round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    logic [PROD_W-FRAC_W-DATA_W:0] top;
    sat_t r;
    q    = p + HALF_LSB;
    top  = q[PROD_W-1:FRAC_W+DATA_W-1];
    r.of = !((&top) || !(|top));
    r.v  = r.of ? (q[PROD_W-1] ? FIX_MIN : FIX_MAX) : q[FRAC_W+DATA_W-1:FRAC_W];
    return r;
  endfunction

  function automatic sat_t sum_sat(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-DATA_W:0] top;
    sat_t r;
    top  = s[SUM_W-1:DATA_W-1];
    r.of = !((&top) || !(|top));
    r.v  = r.of ? (s[SUM_W-1] ? FIX_MIN : FIX_MAX) : s[DATA_W-1:0];
    return r;
  endfunction

  fix_t                       pos_reg;
  fix_t                       vel_reg;
  fix_t                       time_reg;
  fix_t                       kp;
  fix_t                       kv;
  fix_t                       tp;
  logic [STEP_SIZE_W-1:0]     h;
  logic [STEP_SIZE_W-3:0]     h6;
  logic signed [SUM_W-1:0]    sp;
  logic signed [SUM_W-1:0]    sv;
  logic signed [PROD_W-1:0]   prod;
  logic                       restart_q;
  logic                       ov;

  logic signed [DATA_W:0]     rem;
  logic [STEP_SIZE_W-1:0]     h_new;
  fix_t                       mul_a;
  fix_t                       mul_b;
  sat_t                       rnd;
  sat_t                       add_p;
  sat_t                       add_v;
  sat_t                       neg_p;
  sat_t                       neg_tp;
  sat_t                       sum_p;
  sat_t                       sum_v;
  logic signed [SUM_W-1:0]    kp_w;
  logic signed [SUM_W-1:0]    kv_w;

  assign finished = time_reg >= final_time;
  assign skip     = restart_q || finished;

  assign rem   = {final_time[DATA_W-1], final_time} - {time_reg[DATA_W-1], time_reg};
  assign h_new = ($signed({2'b00, step_size}) < rem) ? step_size : rem[STEP_SIZE_W-1:0];

  always_comb begin
    case (ctrl.cw.mul_a)
      MA_HH:   mul_a = {2'b00, h[STEP_SIZE_W-1:1]};
      MA_H:    mul_a = {1'b0, h};
      MA_H6:   mul_a = {3'b000, h6};
      default: mul_a = '0;
    endcase
    case (ctrl.cw.mul_b)
      MB_RECIP: mul_b = RECIP_THIRD;
      MB_KP:    mul_b = kp;
      MB_KV:    mul_b = kv;
      MB_SP:    mul_b = sp[DATA_W-1:0];
      MB_SV:    mul_b = sv[DATA_W-1:0];
      default:  mul_b = '0;
    endcase
  end

  assign rnd    = round_sat(prod);
  assign add_p  = sat_add(pos_reg, rnd.v);
  assign add_v  = sat_add(vel_reg, rnd.v);
  assign neg_p  = sat_neg(pos_reg);
  assign neg_tp = sat_neg(tp);
  assign sum_p  = sum_sat(sp);
  assign sum_v  = sum_sat(sv);
  assign kp_w   = ctrl.cw.weight2 ? (SUM_W'(kp) <<< 1) : SUM_W'(kp);
  assign kv_w   = ctrl.cw.weight2 ? (SUM_W'(kv) <<< 1) : SUM_W'(kv);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (load) begin
      restart_q <= restart;
    end
    if (rst) begin
      pos_reg  <= '0;
      vel_reg  <= '0;
      time_reg <= '0;
      ov       <= 1'b0;
    end else if (ctrl.en) begin
      unique case (ctrl.cw.op) inside
        OP_START: begin
          if (restart_q) begin
            ov       <= 1'b0;
            time_reg <= initial_time;
            pos_reg  <= initial_position;
            vel_reg  <= initial_velocity;
          end else if (!finished) begin
            h  <= h_new;
            kp <= vel_reg;
            kv <= neg_p.v;
            sp <= SUM_W'(vel_reg);
            sv <= SUM_W'(neg_p.v);
            ov <= neg_p.of;
          end else begin
            ov <= 1'b0;
          end
        end
        OP_H6: begin
          h6 <= prod[DATA_W +: STEP_SIZE_W-2];
        end
        OP_TP: begin
          tp <= add_p.v;
          ov <= ov | rnd.of | add_p.of;
        end
        OP_TV: begin
          kp <= add_v.v;
          kv <= neg_tp.v;
          ov <= ov | rnd.of | add_v.of | neg_tp.of;
        end
        OP_SLOPE: begin
          sp <= sp + kp_w;
          sv <= sv + kv_w;
        end
        OP_SUMSAT: begin
          sp <= SUM_W'(sum_p.v);
          sv <= SUM_W'(sum_v.v);
          ov <= ov | sum_p.of | sum_v.of;
        end
        OP_NEWP: begin
          pos_reg <= add_p.v;
          ov      <= ov | rnd.of | add_p.of;
        end
        OP_NEWV: begin
          vel_reg  <= add_v.v;
          time_reg <= time_reg + $signed({1'b0, h});
          ov       <= ov | rnd.of | add_v.of;
        end
        OP_NOP, OP_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign time_now = time_reg;
  assign position = pos_reg;
  assign velocity = vel_reg;
  assign overflow = ov;

endmodule

// File: tb/rk4_oscillator_step_core_tb.sv
// ----------------------------------------------------------------------------
// rk4_oscillator_step_core_tb: self-checking bench for the RK4 oscillator step
// Drives restart and advance words and register writes through the
// valid/ready channels. A bit-exact fixed-point predictor of the integrator
// queues the expected response of every accepted word, and each response
// word is compared field by field. Directed cases cover reset state, zero
// step, saturation, clipped and finished steps and ignored register indexes.
// Random phases reconfigure the core and run integrations under random
// idling and stalls; a backpressure case adds a long receiver hold-off.
// ----------------------------------------------------------------------------
module rk4_oscillator_step_core_tb;
  import rk4os_pkg::*;

  localparam int     RANDOM_ITEMS = 700;
  localparam longint FIX_MAX      = 64'sd2147483647;
  localparam longint FIX_MIN      = -64'sd2147483648;
  localparam logic [IDX_W-1:0] REG_COUNT    = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_LAST_IDX = IDX_W'((1 << IDX_W) - 1);

  logic clk;
  logic rst;

  rk4os_cmd_if cmd_ch ();
  rk4os_rsp_if rsp_ch ();
  rk4os_cfg_if cfg_ch ();

  rk4_oscillator_step_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [STEP_SIZE_W-1:0] step_reg;
  fix_t   stop_time;
  fix_t   start_time;
  fix_t   start_pos;
  fix_t   start_vel;
  longint osc_time;
  longint osc_pos;
  longint osc_vel;

  rsp_word_t expected_states[$];

  bit cmd_idle_on;
  bit rsp_idle_on;
  int rsp_hold_cycles;
  int error_count;
  int ticks_sent;
  int restarts_sent;
  int writes_done;
  int finished_seen;
  int saturated_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d responses outstanding.", expected_states.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  function automatic longint clamp(input longint v, inout bit ov);
    if (v > FIX_MAX) begin
      ov = 1'b1;
      return FIX_MAX;
    end
    if (v < FIX_MIN) begin
      ov = 1'b1;
      return FIX_MIN;
    end
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b, inout bit ov);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_W - 1));
    return clamp(p >>> FRAC_W, ov);
  endfunction

  function automatic rsp_word_t advance_oscillator(input logic restart);
    rsp_word_t w;
    bit        ov;
    longint    stop, h, hh, h6, scale, tp, tv, sp, sv;
    longint    kp[4];
    longint    kv[4];
    ov   = 1'b0;
    stop = longint'(stop_time);
    if (restart) begin
      osc_time = longint'(start_time);
      osc_pos  = longint'(start_pos);
      osc_vel  = longint'(start_vel);
    end else if (osc_time < stop) begin
      h = longint'(step_reg);
      if (stop - osc_time < h) begin
        h = stop - osc_time;
      end
      hh = h >>> 1;
      h6 = h / 6;
      kp[0] = osc_vel;
      kv[0] = clamp(-osc_pos, ov);
      for (int s = 1; s < 4; s++) begin
        scale = (s < 3) ? hh : h;
        tp    = clamp(osc_pos + qmul(scale, kp[s-1], ov), ov);
        tv    = clamp(osc_vel + qmul(scale, kv[s-1], ov), ov);
        kp[s] = tv;
        kv[s] = clamp(-tp, ov);
      end
      sp       = clamp(kp[0] + 2 * kp[1] + 2 * kp[2] + kp[3], ov);
      sv       = clamp(kv[0] + 2 * kv[1] + 2 * kv[2] + kv[3], ov);
      osc_pos  = clamp(osc_pos + qmul(h6, sp, ov), ov);
      osc_vel  = clamp(osc_vel + qmul(h6, sv, ov), ov);
      osc_time = osc_time + h;
    end
    w.time_now = fix_t'(osc_time);
    w.position = fix_t'(osc_pos);
    w.velocity = fix_t'(osc_vel);
    w.finished = (osc_time >= stop);
    w.overflow = ov;
    return w;
  endfunction

  function automatic fix_t to_fix(input longint v);
    if (v > FIX_MAX) return fix_t'(FIX_MAX);
    if (v < FIX_MIN) return fix_t'(FIX_MIN);
    return fix_t'(v);
  endfunction

  task automatic send_cmd(input logic restart);
    int        gap;
    cmd_word_t w;
    gap       = cmd_idle_on ? $urandom_range(0, 15) : 0;
    w.restart = restart;
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.word  <= w;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    expected_states.push_back(advance_oscillator(restart));
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic cmd_release();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] value);
    cfg_word_t w;
    w.index = index;
    w.value = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.word  <= w;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (index)
      REG_STEP_SIZE:        step_reg   = value[STEP_SIZE_W-1:0];
      REG_FINAL_TIME:       stop_time  = value;
      REG_INITIAL_TIME:     start_time = value;
      REG_INITIAL_POSITION: start_pos  = value;
      REG_INITIAL_VELOCITY: start_vel  = value;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin : response_check
      rsp_word_t got;
      rsp_word_t want;
      int        stall_left;
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = rsp_ch.word;
        if (expected_states.size() == 0) begin
          report_error($sformatf("response word with none expected, time_now %h",
                                 got.time_now));
        end else begin
          want = expected_states.pop_front();
          if (want.finished) finished_seen++;
          if (want.overflow) saturated_seen++;
          if (got.time_now !== want.time_now)
            report_error($sformatf("time_now got %h expected %h", got.time_now, want.time_now));
          if (got.position !== want.position)
            report_error($sformatf("position got %h expected %h", got.position, want.position));
          if (got.velocity !== want.velocity)
            report_error($sformatf("velocity got %h expected %h", got.velocity, want.velocity));
          if (got.finished !== want.finished)
            report_error($sformatf("finished got %b expected %b", got.finished, want.finished));
          if (got.overflow !== want.overflow)
            report_error($sformatf("overflow got %b expected %b", got.overflow, want.overflow));
        end
        stall_left = rsp_idle_on ? $urandom_range(0, 15) : 0;
      end
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(1'b0);
    send_cmd(1'b1);
    repeat (3) send_cmd(1'b0);
    cmd_release();
    wait_drain();
  endtask

  task automatic test_directed_cases();
    set_register(REG_STEP_SIZE, '0);
    send_cmd(1'b0);
    cmd_release();
    wait_drain();

    set_register(REG_STEP_SIZE, 32'hffff_ffff);
    set_register(REG_INITIAL_TIME, 32'h8000_0000);
    set_register(REG_FINAL_TIME, 32'h7fff_ffff);
    set_register(REG_INITIAL_POSITION, 32'h7fff_ffff);
    set_register(REG_INITIAL_VELOCITY, 32'h8000_0000);
    send_cmd(1'b1);
    repeat (4) send_cmd(1'b0);
    cmd_release();
    wait_drain();

    set_register(REG_INITIAL_TIME, 32'h7fff_ffff);
    send_cmd(1'b1);
    send_cmd(1'b0);
    cmd_release();
    wait_drain();

    set_register(REG_FINAL_TIME, 32'h8000_0000);
    send_cmd(1'b1);
    send_cmd(1'b0);
    cmd_release();
    wait_drain();

    set_register(REG_COUNT, 32'h1234_5678);
    set_register(REG_LAST_IDX, 32'hffff_ffff);
    set_register(REG_STEP_SIZE, 32'h0000_0001);
    set_register(REG_INITIAL_TIME, 32'h0000_0000);
    set_register(REG_FINAL_TIME, 32'h0100_0000);
    set_register(REG_INITIAL_POSITION, 32'hff00_0000);
    set_register(REG_INITIAL_VELOCITY, 32'h0080_0000);
    send_cmd(1'b1);
    repeat (2) send_cmd(1'b0);
    cmd_release();
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_register(REG_STEP_SIZE, 32'h0010_0000);
    set_register(REG_FINAL_TIME, 32'h0400_0000);
    set_register(REG_INITIAL_TIME, 32'h0000_0000);
    set_register(REG_INITIAL_POSITION, 32'h0100_0000);
    set_register(REG_INITIAL_VELOCITY, 32'h0000_0000);
    cmd_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    rsp_hold_cycles = 120;
    send_cmd(1'b1);
    repeat (12) send_cmd(1'b0);
    cmd_release();
    wait_drain();
    cmd_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    repeat (10) send_cmd(1'b0);
    cmd_release();
    wait_drain();
  endtask

  function automatic fix_t pick_state_value();
    case ($urandom_range(0, 9))
      0:       return fix_t'(FIX_MAX);
      1:       return fix_t'(FIX_MIN);
      2:       return fix_t'($urandom);
      default: return fix_t'(longint'($urandom_range(0, 1 << 27)) - (64'sd1 <<< 26));
    endcase
  endfunction

  task automatic randomize_settings();
    logic [DATA_W-1:0] step;
    fix_t              t0;
    longint            stop;
    case ($urandom_range(0, 15))
      0:       step = '0;
      1:       step = 32'h0000_0001;
      2:       step = 32'hffff_ffff;
      3:       step = $urandom;
      default: step = $urandom_range(1 << 16, 1 << 24);
    endcase
    case ($urandom_range(0, 7))
      0:       t0 = fix_t'(FIX_MIN);
      1:       t0 = fix_t'(FIX_MAX);
      2:       t0 = fix_t'($urandom);
      default: t0 = fix_t'(longint'($urandom_range(0, 1 << 28)) - (64'sd1 <<< 27));
    endcase
    case ($urandom_range(0, 9))
      0:       stop = longint'(fix_t'($urandom));
      1:       stop = longint'(t0) - longint'($urandom_range(0, 1 << 24));
      2:       stop = longint'(t0);
      3, 4:    stop = longint'(t0) + longint'(step[STEP_SIZE_W-1:0]) * $urandom_range(1, 20);
      default: stop = longint'(t0) + longint'($urandom_range(1 << 24, 1 << 28));
    endcase
    if ($urandom_range(0, 7) != 0) set_register(REG_STEP_SIZE, step);
    if ($urandom_range(0, 7) != 0) set_register(REG_INITIAL_TIME, t0);
    if ($urandom_range(0, 7) != 0) set_register(REG_FINAL_TIME, to_fix(stop));
    if ($urandom_range(0, 7) != 0) set_register(REG_INITIAL_POSITION, pick_state_value());
    if ($urandom_range(0, 7) != 0) set_register(REG_INITIAL_VELOCITY, pick_state_value());
    if ($urandom_range(0, 7) == 0) begin
      set_register(IDX_W'($urandom_range(REG_COUNT, REG_LAST_IDX)), $urandom);
    end
  endtask

  task automatic test_random_runs();
    int sent;
    int phase_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cmd_idle_on = $urandom_range(0, 1);
      rsp_idle_on = $urandom_range(0, 1);
      randomize_settings();
      send_cmd(1'b1);
      phase_len = $urandom_range(8, 60);
      repeat (phase_len) send_cmd($urandom_range(0, 11) == 0);
      cmd_release();
      wait_drain();
      sent += phase_len + 1;
    end
  endtask

  initial begin
    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.word     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.word     = '0;
    cmd_idle_on     = 1'b1;
    rsp_idle_on     = 1'b1;
    rsp_hold_cycles = 0;
    error_count     = 0;
    ticks_sent      = 0;
    restarts_sent   = 0;
    writes_done     = 0;
    finished_seen   = 0;
    saturated_seen  = 0;
    step_reg        = STEP_SIZE_RST;
    stop_time       = FINAL_TIME_RST;
    start_time      = INITIAL_TIME_RST;
    start_pos       = INITIAL_POSITION_RST;
    start_vel       = INITIAL_VELOCITY_RST;
    osc_time        = 0;
    osc_pos         = 0;
    osc_vel         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_cases();
    test_backpressure();
    test_random_runs();

    wait_drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d ticks (%0d restarts) with %0d register writes.",
             ticks_sent, restarts_sent, writes_done);
    $display("Responses with finished set: %0d, with saturation: %0d, errors: %0d.",
             finished_seen, saturated_seen, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
